[sv/text_console_writer_unit_macros.svh]
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared concurrent assertion forms for the console writer RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, request codes and the structs shared between modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = COLS * ROWS;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = 16;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int PTR_W  = $clog2(CELLS + 1);

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [7:0]        NEWLINE_CODE = 8'h0A;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;

    typedef struct packed {
        logic scroll;
        logic clear;
    } t_sweep_cmd;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
        logic              done;
    } t_sweep_port;

endpackage

[sv/tcw_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/tcw_sweep.sv]
// ----------------------------------------------------------------------------
// Text console sweep engine
// Walks the screen store with a read/fill pointer and a separate copy write
// pointer: copies rows up one row for a scroll, then fills blank cells (bottom row, or the whole store).
// ----------------------------------------------------------------------------
module tcw_sweep (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tcw_pkg::t_sweep_cmd       i_cmd,
    input  logic [tcw_pkg::CELL_W-1:0] i_rdata,
    output tcw_pkg::t_sweep_port      o_port
);

    localparam logic [1:0] SW_IDLE = 2'd0;
    localparam logic [1:0] SW_COPY = 2'd1;
    localparam logic [1:0] SW_FILL = 2'd2;

    localparam logic [tcw_pkg::PTR_W-1:0] P_COLS = tcw_pkg::PTR_W'(tcw_pkg::COLS);
    localparam logic [tcw_pkg::PTR_W-1:0] P_END  = tcw_pkg::PTR_W'(tcw_pkg::CELLS);
    localparam logic [tcw_pkg::PTR_W-1:0] P_LAST = tcw_pkg::PTR_W'(tcw_pkg::CELLS - 1);
    localparam logic [tcw_pkg::PTR_W-1:0] P_BOT  =
        tcw_pkg::PTR_W'(tcw_pkg::CELLS - tcw_pkg::COLS);

    logic [1:0]                    r_phase, n_phase;
    logic [tcw_pkg::PTR_W-1:0]     r_ptr, n_ptr;
    logic                          r_pend, n_pend;
    logic [tcw_pkg::ADDR_W-1:0]    r_wptr, n_wptr;

    always_comb begin
        n_phase      = r_phase;
        n_ptr        = r_ptr;
        n_pend       = 1'b0;
        n_wptr       = r_wptr;
        o_port.we    = 1'b0;
        o_port.waddr = r_wptr;
        o_port.wdata = i_rdata;
        o_port.raddr = r_ptr[tcw_pkg::ADDR_W-1:0];
        o_port.done  = 1'b0;
        unique case (r_phase)
            SW_IDLE: begin
                if (i_cmd.scroll) begin
                    n_phase = SW_COPY;
                    n_ptr   = P_COLS;
                end else if (i_cmd.clear) begin
                    n_phase = SW_FILL;
                    n_ptr   = '0;
                end
            end
            SW_COPY: begin
                // read cell ptr now, write it one row up next cycle
                o_port.we = r_pend;
                if (r_ptr != P_END) begin
                    n_pend = 1'b1;
                    n_wptr = tcw_pkg::ADDR_W'(r_ptr - P_COLS);
                    n_ptr  = r_ptr + 1'b1;
                end else begin
                    n_phase = SW_FILL;
                    n_ptr   = P_BOT;
                end
            end
            SW_FILL: begin
                o_port.we    = 1'b1;
                o_port.waddr = r_ptr[tcw_pkg::ADDR_W-1:0];
                o_port.wdata = tcw_pkg::BLANK_CELL;
                n_ptr        = r_ptr + 1'b1;
                if (r_ptr == P_LAST) begin
                    o_port.done = 1'b1;
                    n_phase     = SW_IDLE;
                end
            end
            default: begin
                n_phase = SW_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= SW_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
        end
        r_ptr  <= n_ptr;
        r_wptr <= n_wptr;
    end

endmodule

[sv/text_console_writer_unit.sv]
// ----------------------------------------------------------------------------
// Text console writer
// 80x25 character-cell console: put with wrap and scroll, clear, cell read.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Word
// request   in         start & !busy          type, char, attr, read col/row
// result    out        o_valid, one cycle     cursor, scroll flag, cell bytes
//
// A put, an unused code or a read outside the screen reports from the execute
// state; a read inside the screen first waits for the store's registered data.
// A scroll copies rows up one and blanks the bottom row.
// A clear writes every cell once.
// Reset clears the cursor and control only; the store holds garbage until
// cleared or written. The result is never stalled; busy drops with o_valid.
// ----------------------------------------------------------------------------
`include "text_console_writer_unit_macros.svh"

module text_console_writer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_req_type,
    input  logic [7:0]                  i_char_code,
    input  logic [7:0]                  i_attr,
    input  logic [tcw_pkg::COL_W-1:0]   i_read_col,
    input  logic [tcw_pkg::ROW_W-1:0]   i_read_row,
    output logic                        o_valid,
    output logic [tcw_pkg::COL_W-1:0]   o_cur_col,
    output logic [tcw_pkg::ROW_W-1:0]   o_cur_row,
    output logic                        o_did_scroll,
    output logic [7:0]                  o_cell_char,
    output logic [7:0]                  o_cell_attr
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_RDWAIT = 2'd2;
    localparam logic [1:0] ST_SWEEP  = 2'd3;

    localparam logic [tcw_pkg::COL_W-1:0]  LAST_COL = tcw_pkg::COL_W'(tcw_pkg::COLS - 1);
    localparam logic [tcw_pkg::ROW_W-1:0]  LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
    localparam logic [tcw_pkg::ADDR_W-1:0] A_COLS   = tcw_pkg::ADDR_W'(tcw_pkg::COLS);

    logic [1:0]                  r_state, n_state;
    logic [1:0]                  r_req, n_req;
    logic [7:0]                  r_char, n_char;
    logic [7:0]                  r_attr, n_attr;
    logic [tcw_pkg::ADDR_W-1:0]  r_rd_addr, n_rd_addr;
    logic                        r_rd_ok, n_rd_ok;
    logic [tcw_pkg::COL_W-1:0]   r_col, n_col;
    logic [tcw_pkg::ROW_W-1:0]   r_row, n_row;
    logic [tcw_pkg::ADDR_W-1:0]  r_base, n_base;
    logic                        r_valid, n_valid;
    logic                        r_scroll, n_scroll;
    logic [7:0]                  r_cell_char, n_cell_char;
    logic [7:0]                  r_cell_attr, n_cell_attr;

    logic                        put_we;
    logic                        row_inc;
    logic [tcw_pkg::ADDR_W-1:0]  put_addr;
    logic [tcw_pkg::ADDR_W-1:0]  ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_rdata;
    logic                        ram_we;
    logic [tcw_pkg::ADDR_W-1:0]  ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
    tcw_pkg::t_sweep_cmd         sw_cmd;
    tcw_pkg::t_sweep_port        sw_port;

    assign put_addr = r_base + tcw_pkg::ADDR_W'(r_col);
    assign row_inc  = (r_char == tcw_pkg::NEWLINE_CODE) || (r_col == LAST_COL);

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_char      = r_char;
        n_attr      = r_attr;
        n_rd_addr   = r_rd_addr;
        n_rd_ok     = r_rd_ok;
        n_col       = r_col;
        n_row       = r_row;
        n_base      = r_base;
        n_valid     = 1'b0;
        n_scroll    = r_scroll;
        n_cell_char = r_cell_char;
        n_cell_attr = r_cell_attr;
        put_we      = 1'b0;
        ram_raddr   = r_rd_addr;
        sw_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state     = ST_EXEC;
                    n_req       = i_req_type;
                    n_char      = i_char_code;
                    n_attr      = i_attr;
                    n_rd_addr   = tcw_pkg::ADDR_W'(32'(i_read_row) * tcw_pkg::COLS
                                                   + 32'(i_read_col));
                    n_rd_ok     = (32'(i_read_col) < tcw_pkg::COLS)
                               && (32'(i_read_row) < tcw_pkg::ROWS);
                    n_scroll    = 1'b0;
                    n_cell_char = '0;
                    n_cell_attr = '0;
                end
            end
            ST_EXEC: begin
                n_valid = 1'b1;
                n_state = ST_IDLE;
                priority if (r_req == tcw_pkg::REQ_PUT) begin
                    put_we = (r_char != tcw_pkg::NEWLINE_CODE);
                    n_col  = row_inc ? '0 : r_col + 1'b1;
                    if (row_inc) begin
                        if (r_row == LAST_ROW) begin
                            // cursor stays on the last row, screen moves up
                            sw_cmd.scroll = 1'b1;
                            n_scroll      = 1'b1;
                            n_valid       = 1'b0;
                            n_state       = ST_SWEEP;
                        end else begin
                            n_row  = r_row + 1'b1;
                            n_base = r_base + A_COLS;
                        end
                    end
                end else if (r_req == tcw_pkg::REQ_CLEAR) begin
                    sw_cmd.clear = 1'b1;
                    n_col        = '0;
                    n_row        = '0;
                    n_base       = '0;
                    n_valid      = 1'b0;
                    n_state      = ST_SWEEP;
                end else if (r_req == tcw_pkg::REQ_READ && r_rd_ok) begin
                    n_valid = 1'b0;
                    n_state = ST_RDWAIT;
                end else begin
                    // unused code, or a read outside the screen: report now
                    n_valid = 1'b1;
                end
            end
            ST_RDWAIT: begin
                n_cell_char = ram_rdata[7:0];
                n_cell_attr = ram_rdata[15:8];
                n_valid     = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_SWEEP: begin
                ram_raddr = sw_port.raddr;
                if (sw_port.done) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign ram_we    = put_we | sw_port.we;
    assign ram_waddr = sw_port.we ? sw_port.waddr : put_addr;
    assign ram_wdata = sw_port.we ? sw_port.wdata : {r_attr, r_char};

    tcw_sweep u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (sw_cmd),
        .i_rdata (ram_rdata),
        .o_port  (sw_port)
    );

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_col   <= n_col;
            r_row   <= n_row;
            r_base  <= n_base;
        end
        r_req       <= n_req;
        r_char      <= n_char;
        r_attr      <= n_attr;
        r_rd_addr   <= n_rd_addr;
        r_rd_ok     <= n_rd_ok;
        r_scroll    <= n_scroll;
        r_cell_char <= n_cell_char;
        r_cell_attr <= n_cell_attr;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_valid;
    assign o_cur_col    = r_col;
    assign o_cur_row    = r_row;
    assign o_did_scroll = r_scroll;
    assign o_cell_char  = r_cell_char;
    assign o_cell_attr  = r_cell_attr;

    `TCW_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_valid, "accepted word did not raise busy")
    `TCW_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid, "result strobe longer than one cycle")
    `TCW_ASSERT_NOW(a_cursor_range, i_clk, i_rst_n, 1'b1, (r_col <= LAST_COL) && (r_row <= LAST_ROW), "cursor left the screen")
    `TCW_ASSERT_NOW(a_scroll_last_row, i_clk, i_rst_n, o_valid && o_did_scroll, o_cur_row == LAST_ROW, "scroll reported off the last row")

endmodule
